// ===== src/rct_pkg.sv =====
package rct_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 2'd3;

  localparam int unsigned NUM_AXES  = 2;
  localparam int unsigned NUM_LANES = 4;

  localparam int unsigned FRONT_STAGES = 6;

endpackage

// ===== src/rct_div_cell.sv =====
module rct_div_cell #(
  parameter int unsigned W   = 11,
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] rem_i,
  input  logic [W-1:0]   dvs_i,
  input  logic [W-1:0]   quo_i,
  output logic [2*W-1:0] rem_o,
  output logic [W-1:0]   dvs_o,
  output logic [W-1:0]   quo_o
);

  logic [2*W-1:0] dsh;
  logic           fits;
  logic [2*W-1:0] rem_d, rem_q;
  logic [W-1:0]   quo_d, quo_q, dvs_q;

  always_comb begin
    dsh   = {{W{1'b0}}, dvs_i} << BIT;
    fits  = rem_i >= dsh;
    rem_d = fits ? (rem_i - dsh) : rem_i;
    quo_d = quo_i;
    if (fits) begin
      quo_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign dvs_o = dvs_q;

endmodule

// ===== src/rct_div_chain.sv =====
module rct_div_chain #(
  parameter int unsigned W = 11
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] dvd_i,
  input  logic [W-1:0]   dvs_i,
  output logic [W-1:0]   quo_o
);

  logic [2*W-1:0] rem [W+1];
  logic [W-1:0]   dvs [W+1];
  logic [W-1:0]   quo [W+1];

  assign rem[0] = dvd_i;
  assign dvs[0] = dvs_i;
  assign quo[0] = '0;

  // one quotient bit per cell, msb first
  for (genvar i = 0; i < W; i++) begin : g_cell
    rct_div_cell #(
      .W   (W),
      .BIT (W - 1 - i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rem[i]),
      .dvs_i (dvs[i]),
      .quo_i (quo[i]),
      .rem_o (rem[i+1]),
      .dvs_o (dvs[i+1]),
      .quo_o (quo[i+1])
    );
  end

  assign quo_o = quo[W];

endmodule

// ===== src/rect_window_line_clipper.sv =====
// Rectangular window line clipper.
// Slave stream: one segment per beat, tdata = {end_y, end_x, start_y, start_x}
// (start_x lowest), COORD_BITS each, zero padded to whole bytes.
// Master stream: one result per segment. tuser = accepted, tdata =
// {exit_y, exit_x, entry_y, entry_x} (entry_x lowest). Rejected beats carry
// zero points.
// Config: cfg_we_i writes cfg_data_i into window register cfg_idx_i
// (0 x_low, 1 x_high, 2 y_low, 3 y_high); write only while the pipe is empty.
// Throughput: one segment per cycle while the master does not stall. Path from
// the accepting edge to m_axis_tvalid: six front stages (input capture, slab
// bounds, two rounds of cross-multiply compares, point products), one cell
// per quotient bit in the divider chain, then the output register.
// Reset: window returns to [-100,100] x [-100,100], pipe empties.
// A stalled master beat freezes the whole pipe; s_axis_tready drops with it.
module rect_window_line_clipper
  import rct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // entry_x, entry_y, exit_x, exit_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // accepted
  output logic                  m_axis_tuser
);

  localparam int unsigned W      = COORD_BITS;
  localparam int unsigned NW     = W + 1;
  localparam int unsigned PW     = NW + W + 1;
  localparam int unsigned TW     = ((4*W+7)/8)*8;
  localparam int unsigned NST    = FRONT_STAGES + W;
  localparam int unsigned SBW    = 1 + 2*W + 2;

  logic en;
  logic [NST-1:0] vld_q;
  logic           out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // window registers
  logic signed [W-1:0] lo_q [NUM_AXES];
  logic signed [W-1:0] hi_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q[0] <= W'(-100);
      hi_q[0] <= W'(100);
      lo_q[1] <= W'(-100);
      hi_q[1] <= W'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_LOW:  lo_q[0] <= cfg_data_i;
        REG_X_HIGH: hi_q[0] <= cfg_data_i;
        REG_Y_LOW:  lo_q[1] <= cfg_data_i;
        REG_Y_HIGH: hi_q[1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[NST-1];
    end
  end

  // stage A: input capture
  logic signed [W-1:0] a_s_q [NUM_AXES];
  logic signed [W-1:0] a_e_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_s_q[0] <= s_axis_tdata[W-1:0];
      a_s_q[1] <= s_axis_tdata[2*W-1:W];
      a_e_q[0] <= s_axis_tdata[3*W-1:2*W];
      a_e_q[1] <= s_axis_tdata[4*W-1:3*W];
    end
  end

  // stage B: per-axis bounds, entry clamped to at least 0, exit to at most 1
  logic signed [W:0]    b_dl   [NUM_AXES];
  logic                 b_dz   [NUM_AXES];
  logic                 b_pos  [NUM_AXES];
  logic signed [NW-1:0] b_cen  [NUM_AXES];
  logic signed [NW-1:0] b_cln  [NUM_AXES];
  logic [W-1:0]         b_abs  [NUM_AXES];
  logic                 b_okax [NUM_AXES];
  logic signed [NW-1:0] b_ten_d [NUM_AXES];
  logic [W-1:0]         b_ted_d [NUM_AXES];
  logic signed [NW-1:0] b_tln_d [NUM_AXES];
  logic [W-1:0]         b_tld_d [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      b_dl[a]  = NW'(a_e_q[a]) - NW'(a_s_q[a]);
      b_dz[a]  = b_dl[a] == '0;
      b_pos[a] = !b_dl[a][W] && !b_dz[a];
      b_abs[a] = b_dl[a][W] ? W'(-b_dl[a]) : b_dl[a][W-1:0];
      b_cen[a] = b_pos[a] ? (NW'(lo_q[a]) - NW'(a_s_q[a]))
                          : (NW'(a_s_q[a]) - NW'(hi_q[a]));
      b_cln[a] = b_pos[a] ? (NW'(hi_q[a]) - NW'(a_s_q[a]))
                          : (NW'(a_s_q[a]) - NW'(lo_q[a]));
      b_okax[a] = !b_dz[a] || ((lo_q[a] <= a_s_q[a]) && (a_s_q[a] <= hi_q[a]));
      if (!b_dz[a] && (b_cen[a] > 0)) begin
        b_ten_d[a] = b_cen[a];
        b_ted_d[a] = b_abs[a];
      end else begin
        b_ten_d[a] = '0;
        b_ted_d[a] = W'(1);
      end
      if (!b_dz[a] && (b_cln[a] < $signed({1'b0, b_abs[a]}))) begin
        b_tln_d[a] = b_cln[a];
        b_tld_d[a] = b_abs[a];
      end else begin
        b_tln_d[a] = NW'(1);
        b_tld_d[a] = W'(1);
      end
    end
  end

  logic signed [W-1:0]  b_s_q   [NUM_AXES];
  logic [W-1:0]         b_abs_q [NUM_AXES];
  logic                 b_neg_q [NUM_AXES];
  logic                 b_ok_q;
  logic signed [NW-1:0] b_ten_q [NUM_AXES];
  logic [W-1:0]         b_ted_q [NUM_AXES];
  logic signed [NW-1:0] b_tln_q [NUM_AXES];
  logic [W-1:0]         b_tld_q [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        b_s_q[a]   <= a_s_q[a];
        b_abs_q[a] <= b_abs[a];
        b_neg_q[a] <= b_dl[a][W];
        b_ten_q[a] <= b_ten_d[a];
        b_ted_q[a] <= b_ted_d[a];
        b_tln_q[a] <= b_tln_d[a];
        b_tld_q[a] <= b_tld_d[a];
      end
      b_ok_q <= b_okax[0] && b_okax[1];
    end
  end

  // stage C: cross products between the axes
  logic signed [W-1:0]  c_s_q   [NUM_AXES];
  logic [W-1:0]         c_abs_q [NUM_AXES];
  logic                 c_neg_q [NUM_AXES];
  logic                 c_ok_q;
  logic signed [NW-1:0] c_ten_q [NUM_AXES];
  logic [W-1:0]         c_ted_q [NUM_AXES];
  logic signed [NW-1:0] c_tln_q [NUM_AXES];
  logic [W-1:0]         c_tld_q [NUM_AXES];
  logic signed [PW-1:0] c_pe1_q, c_pe2_q, c_pl1_q, c_pl2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_s_q   <= b_s_q;
      c_abs_q <= b_abs_q;
      c_neg_q <= b_neg_q;
      c_ok_q  <= b_ok_q;
      c_ten_q <= b_ten_q;
      c_ted_q <= b_ted_q;
      c_tln_q <= b_tln_q;
      c_tld_q <= b_tld_q;
      c_pe1_q <= b_ten_q[0] * $signed({1'b0, b_ted_q[1]});
      c_pe2_q <= b_ten_q[1] * $signed({1'b0, b_ted_q[0]});
      c_pl1_q <= b_tln_q[0] * $signed({1'b0, b_tld_q[1]});
      c_pl2_q <= b_tln_q[1] * $signed({1'b0, b_tld_q[0]});
    end
  end

  // stage D: largest entry, smallest exit
  logic signed [W-1:0]  d_s_q   [NUM_AXES];
  logic [W-1:0]         d_abs_q [NUM_AXES];
  logic                 d_neg_q [NUM_AXES];
  logic                 d_ok_q;
  logic signed [NW-1:0] d_ten_q, d_tln_q;
  logic [W-1:0]         d_ted_q, d_tld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_s_q   <= c_s_q;
      d_abs_q <= c_abs_q;
      d_neg_q <= c_neg_q;
      d_ok_q  <= c_ok_q;
      if (c_pe1_q < c_pe2_q) begin
        d_ten_q <= c_ten_q[1];
        d_ted_q <= c_ted_q[1];
      end else begin
        d_ten_q <= c_ten_q[0];
        d_ted_q <= c_ted_q[0];
      end
      if (c_pl2_q < c_pl1_q) begin
        d_tln_q <= c_tln_q[1];
        d_tld_q <= c_tld_q[1];
      end else begin
        d_tln_q <= c_tln_q[0];
        d_tld_q <= c_tld_q[0];
      end
    end
  end

  // stage E: entry against exit
  logic signed [W-1:0]  e_s_q   [NUM_AXES];
  logic [W-1:0]         e_abs_q [NUM_AXES];
  logic                 e_neg_q [NUM_AXES];
  logic                 e_ok_q;
  logic signed [NW-1:0] e_ten_q, e_tln_q;
  logic [W-1:0]         e_ted_q, e_tld_q;
  logic signed [PW-1:0] e_q1_q, e_q2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_s_q   <= d_s_q;
      e_abs_q <= d_abs_q;
      e_neg_q <= d_neg_q;
      e_ok_q  <= d_ok_q;
      e_ten_q <= d_ten_q;
      e_ted_q <= d_ted_q;
      e_tln_q <= d_tln_q;
      e_tld_q <= d_tld_q;
      e_q1_q  <= d_tln_q * $signed({1'b0, d_ted_q});
      e_q2_q  <= d_ten_q * $signed({1'b0, d_tld_q});
    end
  end

  // stage F: |delta| * t.n per lane; t.n lies in [0, t.d] when accepted
  logic [2*W-1:0] f_dvd_q [NUM_LANES];
  logic [W-1:0]   f_dvs_q [NUM_LANES];
  logic [SBW-1:0] f_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_dvd_q[0] <= e_abs_q[0] * e_ten_q[W-1:0];
      f_dvd_q[1] <= e_abs_q[1] * e_ten_q[W-1:0];
      f_dvd_q[2] <= e_abs_q[0] * e_tln_q[W-1:0];
      f_dvd_q[3] <= e_abs_q[1] * e_tln_q[W-1:0];
      f_dvs_q[0] <= e_ted_q;
      f_dvs_q[1] <= e_ted_q;
      f_dvs_q[2] <= e_tld_q;
      f_dvs_q[3] <= e_tld_q;
      f_sb_q     <= {e_ok_q && !(e_q1_q < e_q2_q), e_s_q[1], e_s_q[0],
                     e_neg_q[1], e_neg_q[0]};
    end
  end

  // divider chains plus matching sideband line
  logic [W-1:0]   quo [NUM_LANES];
  logic [SBW-1:0] sb_q [W];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rct_div_chain #(
      .W (W)
    ) u_chain (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i (f_dvd_q[l]),
      .dvs_i (f_dvs_q[l]),
      .quo_o (quo[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= f_sb_q;
      for (int i = 1; i < W; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // output register
  logic                acc_sb;
  logic signed [W-1:0] sb_s [NUM_AXES];
  logic                sb_neg [NUM_AXES];
  logic [W:0]          pt  [NUM_LANES];
  logic [4*W-1:0]      data_d, data_q;
  logic                acc_q;

  always_comb begin
    acc_sb    = sb_q[W-1][SBW-1];
    sb_s[1]   = sb_q[W-1][SBW-2 -: W];
    sb_s[0]   = sb_q[W-1][SBW-2-W -: W];
    sb_neg[1] = sb_q[W-1][1];
    sb_neg[0] = sb_q[W-1][0];
    for (int l = 0; l < NUM_LANES; l++) begin
      pt[l] = {sb_s[l%2][W-1], sb_s[l%2]}
            + (sb_neg[l%2] ? -{1'b0, quo[l]} : {1'b0, quo[l]});
    end
    data_d = acc_sb ? {pt[3][W-1:0], pt[2][W-1:0], pt[1][W-1:0], pt[0][W-1:0]}
                    : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      acc_q  <= acc_sb;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TW'(data_q);
  assign m_axis_tuser  = acc_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("rejected beat carries nonzero points");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipe moved during output stall");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[NST-1]))
    else $error("output valid without an item in the last stage");

endmodule
